### hw/rtl/csq_pkg.sv
`default_nettype none

package csq_pkg;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_ADVANCE = 3'd1,
        OP_INSERT  = 3'd2,
        OP_ATTACH  = 3'd3,
        OP_REMOVE  = 3'd4,
        OP_QUERY   = 3'd5
    } csq_op_t;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_FULL       = 2'd1,
        ERR_NO_CURRENT = 2'd2
    } csq_err_t;

    typedef struct packed {
        csq_op_t     operation;
        logic [31:0] entry;
    } csq_request_t;

    typedef struct packed {
        logic [5:0]  count;
        logic        has_current;
        logic [31:0] current_word;
        logic [5:0]  cursor_position;
        csq_err_t    error;
    } csq_result_t;

    // broadcast shift command for the cell row
    typedef struct packed {
        logic open_gap;
        logic close_gap;
    } csq_shift_t;

endpackage

`default_nettype wire

### hw/rtl/csq_cell.sv
`default_nettype none

module csq_cell
    import csq_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int CNT_BITS  = 6,
    parameter int WORD_BITS = 32
) (
    input  wire logic                 clk,
    input  wire csq_shift_t           shift,
    input  wire logic [CNT_BITS-1:0]  pos,
    input  wire logic [CNT_BITS-1:0]  cursor,
    input  wire logic [WORD_BITS-1:0] new_word,
    input  wire logic [WORD_BITS-1:0] lower_word,
    input  wire logic [WORD_BITS-1:0] upper_word,
    output logic      [WORD_BITS-1:0] word,
    output logic      [WORD_BITS-1:0] tap
);

    localparam logic [CNT_BITS-1:0] MY_INDEX = CNT_BITS'(INDEX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (shift.open_gap)
        begin
            if (MY_INDEX == pos)
                word_next = new_word;
            else if (MY_INDEX > pos)
                word_next = lower_word;
        end
        else if (shift.close_gap)
        begin
            if (MY_INDEX >= pos)
                word_next = upper_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign tap  = (cursor == MY_INDEX) ? word_reg : '0;

endmodule

`default_nettype wire

### hw/rtl/cursor_sequence_store.sv
`default_nettype none
// Result strobe (done) is registered from the accepting edge of start through pend_reg,
// then done_reg; the result is registered alongside it.
// One command accepted per cycle; busy stays low.
// Cell row shifts at the accepting edge; the cursor word is gathered in the next cycle.
// Reset clears count, cursor and done; stored words are undefined until written.
// The receiver cannot stall the result.

module cursor_sequence_store
    import csq_pkg::*;
#(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire csq_request_t request,
    output logic              done,
    output csq_result_t       result
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    logic                 accept;
    logic [CNT_BITS-1:0]  count_reg,  count_next;
    logic [CNT_BITS-1:0]  cursor_reg, cursor_next;
    logic                 pend_reg;
    csq_err_t             err_pend_reg, err_next;
    logic                 done_reg;
    csq_result_t          result_reg, result_next;
    csq_shift_t           shift;
    logic [CNT_BITS-1:0]  pos;
    logic                 have;
    logic                 full;
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] cur_word;

    logic [WORD_BITS-1:0] words [DEPTH];
    logic [WORD_BITS-1:0] taps  [DEPTH];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign have     = cursor_reg < count_reg;
    assign full     = count_reg == FULL_COUNT;
    assign new_word = WORD_BITS'(request.entry);

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        err_next    = ERR_OK;
        shift       = '0;
        pos         = cursor_reg;
        if (accept)
        begin
            case (request.operation)
                OP_START:
                begin
                    cursor_next = '0;
                end
                OP_ADVANCE:
                begin
                    if (!have)
                        err_next = ERR_NO_CURRENT;
                    else
                        cursor_next = cursor_reg + 1'b1;
                end
                OP_INSERT:
                begin
                    if (full)
                        err_next = ERR_FULL;
                    else
                    begin
                        pos            = have ? cursor_reg : '0;
                        shift.open_gap = 1'b1;
                        cursor_next    = pos;
                        count_next     = count_reg + 1'b1;
                    end
                end
                OP_ATTACH:
                begin
                    if (full)
                        err_next = ERR_FULL;
                    else
                    begin
                        pos            = have ? cursor_reg + 1'b1 : count_reg;
                        shift.open_gap = 1'b1;
                        cursor_next    = pos;
                        count_next     = count_reg + 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (!have)
                        err_next = ERR_NO_CURRENT;
                    else
                    begin
                        shift.close_gap = 1'b1;
                        count_next      = count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] lower;
        logic [WORD_BITS-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = new_word;
        end
        else
        begin : g_mid_lo
            assign lower = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = words[i];
        end
        else
        begin : g_mid_hi
            assign upper = words[i+1];
        end

        csq_cell #(
            .INDEX     (i),
            .CNT_BITS  (CNT_BITS),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk        (clk),
            .shift      (shift),
            .pos        (pos),
            .cursor     (cursor_reg),
            .new_word   (new_word),
            .lower_word (lower),
            .upper_word (upper),
            .word       (words[i]),
            .tap        (taps[i])
        );
    end

    always_comb
    begin
        cur_word = '0;
        for (int i = 0; i < DEPTH; i++)
            cur_word = cur_word | taps[i];
    end

    always_comb
    begin
        result_next.count           = 6'(count_reg);
        result_next.has_current     = have;
        result_next.current_word    = have ? 32'(cur_word) : 32'd0;
        result_next.cursor_position = 6'(cursor_reg);
        result_next.error           = err_pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            pend_reg   <= accept;
            done_reg   <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        err_pend_reg <= err_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("count exceeds depth");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond count");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err_next == ERR_FULL) |=> count_reg == $past(count_reg))
        else $error("rejected request changed count");

    a_no_cur_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.has_current) |->
        (result.current_word == 32'd0 && result.cursor_position == result.count))
        else $error("inconsistent empty cursor result");

    a_nocur_err: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.error == ERR_NO_CURRENT) |-> !result.has_current)
        else $error("no-current error with current word");
`endif

endmodule

`default_nettype wire

### verif/csq_result_checker.sv
module csq_result_checker
    import csq_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         busy,
    input  wire csq_request_t request,
    input  wire logic         done,
    input  wire csq_result_t  result,
    output int                fails,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] seq_words [0:DEPTH-1];
    int          seq_count;
    int          seq_cursor;
    csq_result_t expected_results [$];
    int          mismatch_count = 0;

    task automatic apply_command(input csq_request_t req, output csq_result_t res);
        bit       have;
        csq_err_t err;
        int       i;
        have = seq_cursor < seq_count;
        err  = ERR_OK;
        case (req.operation)
            OP_START:
                seq_cursor = 0;
            OP_ADVANCE:
                if (!have)
                    err = ERR_NO_CURRENT;
                else
                    seq_cursor++;
            OP_INSERT:
                if (seq_count >= DEPTH)
                    err = ERR_FULL;
                else
                begin
                    if (!have)
                        seq_cursor = 0;
                    for (i = seq_count; i > seq_cursor; i--)
                        seq_words[i] = seq_words[i-1];
                    seq_words[seq_cursor] = req.entry;
                    seq_count++;
                end
            OP_ATTACH:
                if (seq_count >= DEPTH)
                    err = ERR_FULL;
                else if (!have)
                begin
                    seq_cursor = seq_count;
                    seq_words[seq_cursor] = req.entry;
                    seq_count++;
                end
                else
                begin
                    for (i = seq_count; i > seq_cursor + 1; i--)
                        seq_words[i] = seq_words[i-1];
                    seq_words[seq_cursor+1] = req.entry;
                    seq_count++;
                    seq_cursor++;
                end
            OP_REMOVE:
                if (!have)
                    err = ERR_NO_CURRENT;
                else
                begin
                    for (i = seq_cursor; i + 1 < seq_count; i++)
                        seq_words[i] = seq_words[i+1];
                    seq_count--;
                end
            default:
                ;
        endcase
        have                = seq_cursor < seq_count;
        res.count           = 6'(seq_count);
        res.has_current     = have;
        res.current_word    = have ? seq_words[seq_cursor] : 32'd0;
        res.cursor_position = 6'(seq_cursor);
        res.error           = err;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        csq_result_t exp_res;
        csq_result_t new_res;
        if (!rst_n)
        begin
            seq_count  = 0;
            seq_cursor = 0;
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result %p", $time, result);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (result.count !== exp_res.count)
                    begin
                        mismatch_count++;
                        $display("%0t: count expected %0d actual %0d",
                                 $time, exp_res.count, result.count);
                    end
                    if (result.has_current !== exp_res.has_current)
                    begin
                        mismatch_count++;
                        $display("%0t: has_current expected %0b actual %0b",
                                 $time, exp_res.has_current, result.has_current);
                    end
                    if (result.current_word !== exp_res.current_word)
                    begin
                        mismatch_count++;
                        $display("%0t: current_word expected %h actual %h",
                                 $time, exp_res.current_word, result.current_word);
                    end
                    if (result.cursor_position !== exp_res.cursor_position)
                    begin
                        mismatch_count++;
                        $display("%0t: cursor_position expected %0d actual %0d",
                                 $time, exp_res.cursor_position, result.cursor_position);
                    end
                    if (result.error !== exp_res.error)
                    begin
                        mismatch_count++;
                        $display("%0t: error expected %0d actual %0d",
                                 $time, exp_res.error, result.error);
                    end
                end
            end
            if (start && !busy)
            begin
                apply_command(request, new_res);
                expected_results.push_back(new_res);
            end
        end
        pending <= expected_results.size();
        fails   <= mismatch_count;
    end

endmodule

### verif/tb_cursor_sequence_store.sv
module tb_cursor_sequence_store;
    import csq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam csq_op_t OP_UNUSED_6 = csq_op_t'(3'd6);
    localparam csq_op_t OP_UNUSED_7 = csq_op_t'(3'd7);

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    csq_request_t request;
    logic         done;
    csq_result_t  result;
    int           fails;
    int           pending;

    cursor_sequence_store u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    csq_result_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .fails   (fails),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    task automatic issue(input csq_op_t op, input logic [31:0] word, input bit may_idle);
        csq_request_t req;
        req.operation = op;
        req.entry     = word;
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // growing phases favor insert/attach, shrinking phases favor start/remove
    function automatic csq_op_t pick_op(input bit growing);
        int roll;
        roll = $urandom_range(0, 99);
        if (growing)
        begin
            if (roll < 35)      return OP_INSERT;
            else if (roll < 70) return OP_ATTACH;
            else if (roll < 78) return OP_ADVANCE;
            else if (roll < 84) return OP_START;
            else if (roll < 90) return OP_REMOVE;
            else if (roll < 95) return OP_QUERY;
        end
        else
        begin
            if (roll < 45)      return OP_REMOVE;
            else if (roll < 60) return OP_START;
            else if (roll < 72) return OP_ADVANCE;
            else if (roll < 80) return OP_INSERT;
            else if (roll < 86) return OP_ATTACH;
            else if (roll < 93) return OP_QUERY;
        end
        return $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
    endfunction

    initial
    begin
        bit quiet;
        rst_n   = 1'b0;
        start   <= 1'b0;
        request <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store corner cases
        issue(OP_QUERY,    32'h0, 1);
        issue(OP_START,    32'h0, 1);
        issue(OP_ADVANCE,  32'h0, 1);
        issue(OP_REMOVE,   32'h0, 1);
        issue(OP_UNUSED_6, 32'hFFFF_FFFF, 1);
        issue(OP_UNUSED_7, 32'h0, 1);
        // build a short sequence
        issue(OP_INSERT,   32'h0000_0000, 1);
        issue(OP_ATTACH,   32'hFFFF_FFFF, 1);
        issue(OP_INSERT,   32'h5A5A_5A5A, 1);
        issue(OP_START,    32'h0, 1);
        // walk off the end
        issue(OP_ADVANCE,  32'h0, 0);
        issue(OP_ADVANCE,  32'h0, 0);
        issue(OP_ADVANCE,  32'h0, 0);
        issue(OP_ADVANCE,  32'h0, 0);
        // no current word: insert at front, attach at end
        issue(OP_INSERT,   32'hA5A5_A5A5, 1);
        issue(OP_ADVANCE,  32'h0, 1);
        issue(OP_ADVANCE,  32'h0, 1);
        issue(OP_ADVANCE,  32'h0, 1);
        issue(OP_ADVANCE,  32'h0, 1);
        issue(OP_ATTACH,   32'h1234_5678, 1);
        issue(OP_START,    32'h0, 1);
        issue(OP_REMOVE,   32'h0, 1);
        issue(OP_ADVANCE,  32'h0, 1);
        issue(OP_REMOVE,   32'h0, 1);
        issue(OP_QUERY,    32'h0, 1);

        for (int blk = 0; blk < 4; blk++)
        begin
            quiet = (blk == 3) || ($urandom_range(0, 3) == 0);
            repeat (55)
                issue(pick_op(1'b1), pick_word(), !quiet);
            repeat (65)
                issue(pick_op(1'b0), pick_word(), !quiet);
        end

        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
